// File: sv/assert_macros.svh
// Assertion macros used by the port-level checker of the table block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/act_pkg.sv
// Package for the aging capability table: sizes, operation and status codes,
// the stored entry layout and the controller states. No dependencies.
`default_nettype none

package act_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int COUNT_OUT_W = 5;

  localparam logic [7:0] EXPIRY_RESET = 8'd15;
  localparam logic [7:0] AGE_MAX = 8'd255;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_USE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [63:0] hash_upper;
    logic [63:0] hash_middle;
    logic [31:0] hash_lower;
    logic [7:0]  age;
    logic [15:0] insert_order;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // The reported count saturates at the largest value of the output field.
  function automatic logic [COUNT_OUT_W-1:0] count_out(input logic [CNT_W-1:0] c);
    if ({{COUNT_OUT_W{1'b0}}, c} > (CNT_W + COUNT_OUT_W)'(31)) begin
      return COUNT_OUT_W'(31);
    end else begin
      return COUNT_OUT_W'(c);
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/act_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; width and depth come from the parameters.
`default_nettype none

module act_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/aging_capability_table.sv
// Top level of the aging capability table: controller, valid bits and count.
// Depends on act_pkg and act_ram.
//
// Usage: an operation word (op and the three hash parts) is taken at a clock
// edge where start is high and busy is low; busy stays high until the result
// is out. Operations: insert a hash with age zero into the lowest free slot,
// use (remove the newest matching slot), and tick (age all slots and drop
// those whose age exceeds expiry_ticks). Code 3 changes nothing.
// Every operation gives one result word: result_valid is high for one cycle
// with status and entries_in_use. The receiver cannot stall it.
// The controller walks the table once through the entry RAM, one slot read per
// cycle with the compare or age update in the cycle after the read; a tick or
// use visits every slot, while an insert stops at the first free slot.
// busy drops in the cycle the result shows, so the next word can be taken then.
// The user must write expiry_ticks via cfg_write/cfg_data only while busy is low.
// Reset empties the table, clears the insert stamp and sets expiry_ticks to 15;
// no clearing pass is needed since slot validity is held in flip-flops.
`default_nettype none

module aging_capability_table (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         op,
  input  wire logic [63:0]                        hash_upper,
  input  wire logic [63:0]                        hash_middle,
  input  wire logic [31:0]                        hash_lower,
  input  wire logic                               cfg_write,
  input  wire logic [7:0]                         cfg_data,
  output logic                                    result_valid,
  output logic [1:0]                              status,
  output logic [act_pkg::COUNT_OUT_W-1:0]         entries_in_use
);

  import act_pkg::*;

  localparam logic [IDX_W:0] ISS_END = (IDX_W + 1)'(TABLE_ENTRIES);

  state_t state, state_next;

  logic [IDX_W:0]          iss_cnt;
  logic                    pend;
  logic [IDX_W-1:0]        d_idx;
  logic [1:0]              op_q;
  logic [63:0]             hu_q;
  logic [63:0]             hm_q;
  logic [31:0]             hl_q;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]        count;
  logic [15:0]             seq;
  logic [7:0]              expiry;
  logic                    found;
  logic [IDX_W-1:0]        pick;
  logic [15:0]             best;

  logic                    issuing;
  logic [IDX_W-1:0]        iss_idx;
  logic                    ins_hit;
  logic                    tick_act;
  logic                    use_match;
  logic                    expire;
  logic                    hash_eq;
  logic [7:0]              age_inc;
  logic [15:0]             stamp_gap;
  logic                    rd_en;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  entry_t                  wr_entry;
  entry_t                  rd_entry;
  logic [$bits(entry_t)-1:0] rd_data;

  act_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (iss_idx),
    .rdata (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);
  assign issuing  = (iss_cnt < ISS_END);
  assign iss_idx  = iss_cnt[IDX_W-1:0];
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ins_hit || (!issuing && !pend)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The tick write-back goes to the slot read in the cycle before, while the
  // read port has already moved on to the next slot, so the two never collide.
  always_comb begin
    rd_en     = (state == S_SCAN) && issuing;
    ins_hit   = (state == S_SCAN) && (op_q == OP_INSERT) && issuing && !valid[iss_idx];
    hash_eq   = (rd_entry.hash_upper == hu_q) && (rd_entry.hash_middle == hm_q) &&
                (rd_entry.hash_lower == hl_q);
    tick_act  = (state == S_SCAN) && pend && (op_q == OP_TICK) && valid[d_idx];
    use_match = (state == S_SCAN) && pend && (op_q == OP_USE) && valid[d_idx] && hash_eq;
    age_inc   = (rd_entry.age == AGE_MAX) ? AGE_MAX : rd_entry.age + 8'd1;
    expire    = tick_act && (age_inc > expiry);
    stamp_gap = seq - rd_entry.insert_order - 16'd1;

    wr_en    = ins_hit || tick_act;
    wr_addr  = d_idx;
    wr_entry = rd_entry;
    wr_entry.age = age_inc;
    if (ins_hit) begin
      wr_addr = iss_idx;
      wr_entry.hash_upper   = hu_q;
      wr_entry.hash_middle  = hm_q;
      wr_entry.hash_lower   = hl_q;
      wr_entry.age          = 8'd0;
      wr_entry.insert_order = seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      iss_cnt      <= '0;
      pend         <= 1'b0;
      valid        <= '0;
      count        <= '0;
      seq          <= 16'd0;
      expiry       <= EXPIRY_RESET;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pend         <= rd_en;
      result_valid <= (state == S_DONE);
      if (cfg_write) begin
        expiry <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          iss_cnt <= '0;
          found   <= 1'b0;
        end
        S_SCAN: begin
          if (issuing) begin
            iss_cnt <= iss_cnt + (IDX_W + 1)'(1);
          end
          if (ins_hit) begin
            valid[iss_idx] <= 1'b1;
            count          <= count + CNT_W'(1);
            seq            <= seq + 16'd1;
            found          <= 1'b1;
          end
          if (expire) begin
            valid[d_idx] <= 1'b0;
            count        <= count - CNT_W'(1);
          end
          if (use_match && (!found || (stamp_gap < best))) begin
            found <= 1'b1;
          end
        end
        S_DONE: begin
          if ((op_q == OP_USE) && found) begin
            valid[pick] <= 1'b0;
            count       <= count - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    d_idx <= iss_idx;
    if ((state == S_IDLE) && start) begin
      op_q <= op;
      hu_q <= hash_upper;
      hm_q <= hash_middle;
      hl_q <= hash_lower;
    end
    // Strict less-than keeps the lowest slot among equal distances.
    if (use_match && (!found || (stamp_gap < best))) begin
      pick <= d_idx;
      best <= stamp_gap;
    end
    if (state == S_DONE) begin
      if ((op_q == OP_USE) && found) begin
        entries_in_use <= count_out(count - CNT_W'(1));
      end else begin
        entries_in_use <= count_out(count);
      end
      if ((op_q == OP_INSERT) && !found) begin
        status <= ST_FULL;
      end else if ((op_q == OP_USE) && !found) begin
        status <= ST_NO_MATCH;
      end else begin
        status <= ST_DONE;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/act_checker.sv
// Port-level checker for the aging capability table, bound to the top level.
// Depends on act_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module act_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               result_valid,
  input wire logic [1:0]                         status,
  input wire logic [act_pkg::COUNT_OUT_W-1:0]    entries_in_use
);

  import act_pkg::*;

  // An accepted word keeps the block busy in the next cycle.
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

  // A result word is a single-cycle strobe with the block free to accept.
  `ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe repeated")
  `ASSERT_SAME(a_strobe_idle, result_valid, !busy, "result shown while busy")

  // A full report means every slot is in use.
  `ASSERT_SAME(a_full_count, result_valid && (status == ST_FULL),
    entries_in_use == COUNT_OUT_W'(TABLE_ENTRIES), "table full with free slots")

endmodule

bind aging_capability_table act_checker u_act_checker (.*);

`default_nettype wire

// File: test/act_table_checker.sv
`timescale 1ns / 100ps
// Checker for the aging capability table. It keeps its own copy of the table,
// predicts status and entry count per accepted word and compares the results.
// Depends on act_pkg for the table size, the count width and the codes.

module act_table_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire logic [1:0]                      op,
  input  wire logic [63:0]                     hash_upper,
  input  wire logic [63:0]                     hash_middle,
  input  wire logic [31:0]                     hash_lower,
  input  wire logic                            cfg_write,
  input  wire logic [7:0]                      cfg_data,
  input  wire logic                            result_valid,
  input  wire logic [1:0]                      status,
  input  wire logic [act_pkg::COUNT_OUT_W-1:0] entries_in_use,
  output int                                   mismatches,
  output int                                   results_owed
);

  import act_pkg::*;

  typedef struct packed {
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] count;
  } table_outcome_t;

  logic        slot_valid [TABLE_ENTRIES];
  logic [63:0] slot_upper [TABLE_ENTRIES];
  logic [63:0] slot_middle [TABLE_ENTRIES];
  logic [31:0] slot_lower [TABLE_ENTRIES];
  logic [7:0]  slot_age [TABLE_ENTRIES];
  logic [15:0] slot_stamp [TABLE_ENTRIES];
  logic [15:0] next_stamp;
  logic [7:0]  expiry;

  table_outcome_t outcome_q [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic apply_table_op(input logic [1:0] code, input logic [63:0] hu,
                                input logic [63:0] hm, input logic [31:0] hl,
                                output table_outcome_t res);
    int pick;
    int live;
    logic [15:0] stamp_gap;
    logic [15:0] best;
    res.status = ST_DONE;
    pick = -1;
    best = '0;
    case (code)
      OP_INSERT: begin
        res.status = ST_FULL;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!slot_valid[i] && res.status == ST_FULL) begin
            slot_valid[i] = 1'b1;
            slot_upper[i] = hu;
            slot_middle[i] = hm;
            slot_lower[i] = hl;
            slot_age[i] = 8'd0;
            slot_stamp[i] = next_stamp;
            next_stamp = next_stamp + 16'd1;
            res.status = ST_DONE;
          end
        end
      end
      OP_USE: begin
        // The newest match is the one with the smallest wrapped stamp distance.
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot_valid[i] && slot_upper[i] == hu && slot_middle[i] == hm &&
              slot_lower[i] == hl) begin
            stamp_gap = next_stamp - slot_stamp[i] - 16'd1;
            if (pick < 0 || stamp_gap < best) begin
              pick = i;
              best = stamp_gap;
            end
          end
        end
        if (pick < 0) begin
          res.status = ST_NO_MATCH;
        end else begin
          slot_valid[pick] = 1'b0;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot_valid[i]) begin
            if (slot_age[i] != AGE_MAX) slot_age[i] = slot_age[i] + 8'd1;
            if (slot_age[i] > expiry) slot_valid[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    live = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_valid[i]) live++;
    end
    res.count = (live > 31) ? COUNT_OUT_W'(31) : COUNT_OUT_W'(live);
  endtask

  always @(posedge clk) begin : watch
    table_outcome_t predicted;
    table_outcome_t owed;
    int delta;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
      next_stamp = '0;
      expiry = EXPIRY_RESET;
      outcome_q.delete();
      results_owed <= 0;
    end else begin
      delta = 0;
      // A result and a new word can meet in one cycle; the result is older.
      if (result_valid) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result word with no operation waiting");
        end else begin
          owed = outcome_q.pop_front();
          delta = delta - 1;
          if (status !== owed.status) begin
            report_mismatch($sformatf("status got %0d want %0d", status, owed.status));
          end
          if (entries_in_use !== owed.count) begin
            report_mismatch($sformatf("entries_in_use got %0d want %0d",
                                      entries_in_use, owed.count));
          end
        end
      end
      if (cfg_write) expiry = cfg_data;
      if (start && !busy) begin
        apply_table_op(op, hash_upper, hash_middle, hash_lower, predicted);
        outcome_q.push_back(predicted);
        delta = delta + 1;
      end
      results_owed <= results_owed + delta;
    end
  end

endmodule

// File: test/tb_aging_capability_table.sv
`timescale 1ns / 100ps
// Top of the aging capability table testbench: clock, reset and stimulus,
// with act_table_checker beside the block. Depends on act_pkg and the RTL.

module tb_aging_capability_table;
  import act_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_WORDS = 305;
  localparam int POOL_SIZE = 8;
  localparam int PHASES = 6;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [1:0]             op;
  logic [63:0]            hash_upper;
  logic [63:0]            hash_middle;
  logic [31:0]            hash_lower;
  logic                   cfg_write;
  logic [7:0]             cfg_data;
  logic                   result_valid;
  logic [1:0]             status;
  logic [COUNT_OUT_W-1:0] entries_in_use;
  int                     mismatches;
  int                     results_owed;

  logic        quiet;
  logic [63:0] pool_upper [POOL_SIZE];
  logic [63:0] pool_middle [POOL_SIZE];
  logic [31:0] pool_lower [POOL_SIZE];
  int          expiry_plan [PHASES];

  aging_capability_table dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .hash_upper     (hash_upper),
    .hash_middle    (hash_middle),
    .hash_lower     (hash_lower),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .result_valid   (result_valid),
    .status         (status),
    .entries_in_use (entries_in_use)
  );

  act_table_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .hash_upper     (hash_upper),
    .hash_middle    (hash_middle),
    .hash_lower     (hash_lower),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .result_valid   (result_valid),
    .status         (status),
    .entries_in_use (entries_in_use),
    .mismatches     (mismatches),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_aging_capability_table failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Holds one word on the ports until it is taken, then idles for a drawn gap.
  // With a zero gap start stays high so the next word follows at once.
  task automatic send_word(input logic [1:0] code, input logic [63:0] hu,
                           input logic [63:0] hm, input logic [31:0] hl);
    int gap;
    start <= 1'b1;
    op <= code;
    hash_upper <= hu;
    hash_middle <= hm;
    hash_lower <= hl;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (busy || results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_expiry(input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_upper[i] = rand64();
      pool_middle[i] = rand64();
      pool_lower[i] = $urandom();
    end
  endtask

  // Hashes mostly come from a small pool so that inserts and uses meet;
  // some differ from a pool hash in one bit and some are fresh.
  task automatic send_random_op(input int insert_weight);
    int roll;
    int sel;
    int pick;
    logic [1:0] code;
    logic [63:0] hu;
    logic [63:0] hm;
    logic [31:0] hl;
    roll = $urandom_range(0, 99);
    if (roll < insert_weight) code = OP_INSERT;
    else if (roll < insert_weight + 35) code = OP_USE;
    else if (roll < 97) code = OP_TICK;
    else code = OP_UNUSED;
    sel = $urandom_range(0, POOL_SIZE + 1);
    pick = $urandom_range(0, POOL_SIZE - 1);
    hu = pool_upper[pick];
    hm = pool_middle[pick];
    hl = pool_lower[pick];
    if (code == OP_TICK || code == OP_UNUSED || sel == POOL_SIZE + 1) begin
      hu = rand64();
      hm = rand64();
      hl = $urandom();
    end else if (sel == POOL_SIZE) begin
      case ($urandom_range(0, 2))
        0: hu = hu ^ (64'd1 << $urandom_range(0, 63));
        1: hm = hm ^ (64'd1 << $urandom_range(0, 63));
        default: hl = hl ^ (32'd1 << $urandom_range(0, 31));
      endcase
    end
    send_word(code, hu, hm, hl);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    op = OP_INSERT;
    hash_upper = '0;
    hash_middle = '0;
    hash_lower = '0;
    cfg_write = 1'b0;
    cfg_data = EXPIRY_RESET;
    quiet = 1'b0;
    expiry_plan = '{1, 254, 2, 0, 8, 120};
    expiry_plan[3] = $urandom_range(3, 253);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    refill_pool();

    // Empty table, ignored code, all-zero and all-one hashes and duplicates.
    send_word(OP_USE, '0, '0, '0);
    send_word(OP_TICK, rand64(), rand64(), $urandom());
    send_word(OP_UNUSED, rand64(), rand64(), $urandom());
    send_word(OP_INSERT, '0, '0, '0);
    send_word(OP_INSERT, '1, '1, '1);
    send_word(OP_INSERT, '1, '1, '1);
    send_word(OP_USE, '1, '1, '1);
    send_word(OP_USE, '1, '1, '1);
    send_word(OP_USE, '1, '1, '1);
    // Fill the table, then one insert too many.
    for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
      send_word(OP_INSERT, pool_upper[i % POOL_SIZE], pool_middle[i % POOL_SIZE],
                pool_lower[i % POOL_SIZE]);
    end
    send_word(OP_INSERT, rand64(), rand64(), $urandom());
    send_word(OP_USE, pool_upper[0], pool_middle[0], pool_lower[0] ^ 32'd1);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      int weight;
      write_expiry(8'(expiry_plan[p]));
      refill_pool();
      weight = $urandom_range(30, 55);
      repeat (PHASE_WORDS) send_random_op(weight);
      wait_idle();
    end

    if (mismatches == 0 && results_owed == 0) begin
      $display("tb_aging_capability_table passed");
    end else begin
      $display("tb_aging_capability_table failed");
    end
    $finish;
  end

endmodule
